/* rtl/canrxf_pkg.sv */
// shared types and constants for the can receive filter and frame ring
`default_nettype none

package canrxf_pkg;

    localparam int DEF_RING_DEPTH   = 16;
    localparam int DEF_FILTER_SLOTS = 4;

    localparam int ID_W       = 11;
    localparam int DLC_W      = 4;
    localparam int DATA_W     = 64;
    localparam int FRAME_W    = ID_W + DLC_W + DATA_W;
    localparam int TDATA_W    = 80;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int CNT_W      = 3;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WORD_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WORD_LAST = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_BUS  = 2'd0,
        KIND_LOOP = 2'd1,
        KIND_POP  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_REJECT = 2'd2,
        STATUS_FULL   = 2'd3
    } rx_status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } canrxf_cmd_t;

    typedef struct packed {
        logic out_free;
    } canrxf_sts_t;

endpackage

`default_nettype wire

/* rtl/canrxf_ctrl.sv */
// controller state machine: accept a transaction, then execute it once the output is free
`default_nettype none

module canrxf_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    input  canrxf_pkg::canrxf_sts_t  sts,
    output canrxf_pkg::canrxf_cmd_t  cmd
);
    import canrxf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/canrxf_dp.sv */
// datapath: filter registers, acceptance match, frame ring memory, pointers, result register
`default_nettype none

module canrxf_dp #(
    parameter int RING_DEPTH   = canrxf_pkg::DEF_RING_DEPTH,
    parameter int FILTER_SLOTS = canrxf_pkg::DEF_FILTER_SLOTS
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_we,
    input  wire  [canrxf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [canrxf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire  [canrxf_pkg::KIND_W-1:0]         s_tuser,
    input  wire  [canrxf_pkg::TDATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [canrxf_pkg::STATUS_W-1:0]       m_tuser,
    output logic [canrxf_pkg::TDATA_W-1:0]        m_tdata,
    input  canrxf_pkg::canrxf_cmd_t               cmd,
    output canrxf_pkg::canrxf_sts_t               sts
);
    import canrxf_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic [CNT_W-1:0]      filter_count_reg;
    logic [CFG_DATA_W-1:0] filter_word_reg [FILTER_SLOTS];

    kind_t              kind_reg;
    logic [FRAME_W-1:0] frame_reg;

    logic [FRAME_W-1:0] ring_mem [RING_DEPTH];
    logic [FRAME_W-1:0] rd_data_reg;
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW-1:0]      rd_ptr_next;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_user_reg;
    logic [TDATA_W-1:0]  m_data_reg;

    logic [CNT_W-1:0]        active_cnt;
    logic [FILTER_SLOTS-1:0] hit;
    logic                    id_accepted;
    logic [AW-1:0]           wr_ptr_inc;
    logic                    ring_full;
    logic                    ring_empty;
    logic                    do_store;
    logic                    do_pop;
    rx_status_t              res_status;
    logic [TDATA_W-1:0]      res_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_count_reg <= '0;
        end else if (cfg_we && (cfg_index == REG_FILTER_COUNT)) begin
            filter_count_reg <= cfg_wdata[CNT_W-1:0];
        end
    end

    for (genvar g = 0; g < FILTER_SLOTS; g++) begin : g_slot
        if (g <= int'(REG_FILTER_WORD_LAST - REG_FILTER_WORD_0)) begin : g_wr
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    filter_word_reg[g] <= '0;
                end else if (cfg_we && (cfg_index == CFG_IDX_W'(int'(REG_FILTER_WORD_0) + g))) begin
                    filter_word_reg[g] <= cfg_wdata;
                end
            end
        end else begin : g_fixed
            // no register index reaches this slot
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    filter_word_reg[g] <= '0;
                end
            end
        end
    end

    // capture the incoming transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= kind_t'(s_tuser);
            frame_reg <= s_tdata[FRAME_W-1:0];
        end
    end

    // acceptance filter, all slots compared side by side
    always_comb begin
        active_cnt = (filter_count_reg > CNT_W'(FILTER_SLOTS)) ? CNT_W'(FILTER_SLOTS)
                                                              : filter_count_reg;
        for (int i = 0; i < FILTER_SLOTS; i++) begin
            hit[i] = (CNT_W'(i) < active_cnt) &&
                     ((frame_reg[ID_W-1:0] & filter_word_reg[i][2*ID_W-1:ID_W]) ==
                      (filter_word_reg[i][ID_W-1:0] & filter_word_reg[i][2*ID_W-1:ID_W]));
        end
        id_accepted = (active_cnt == '0) || (|hit);
    end

    assign wr_ptr_inc = wr_ptr_reg + AW'(1);
    assign ring_full  = (wr_ptr_inc == rd_ptr_reg);
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);

    always_comb begin
        res_status = STATUS_DONE;
        res_data   = '0;
        do_store   = 1'b0;
        do_pop     = 1'b0;
        case (kind_reg)
            KIND_BUS: begin
                if (!id_accepted) begin
                    res_status = STATUS_REJECT;
                end else if (ring_full) begin
                    res_status = STATUS_FULL;
                end else begin
                    do_store = 1'b1;
                end
            end
            KIND_LOOP: begin
                if (ring_full) begin
                    res_status = STATUS_FULL;
                end else begin
                    do_store = 1'b1;
                end
            end
            KIND_POP: begin
                if (ring_empty) begin
                    res_status = STATUS_EMPTY;
                end else begin
                    do_pop   = 1'b1;
                    res_data = {{(TDATA_W-FRAME_W){1'b0}}, rd_data_reg};
                end
            end
            default: begin
                res_status = STATUS_DONE;
            end
        endcase
    end

    assign wr_ptr_next = (cmd.commit && do_store) ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = (cmd.commit && do_pop) ? rd_ptr_reg + AW'(1) : rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // frame ring; the read port follows the read pointer every cycle
    always_ff @(posedge aclk) begin
        if (cmd.commit && do_store) begin
            ring_mem[wr_ptr_reg] <= frame_reg;
        end
        rd_data_reg <= ring_mem[rd_ptr_reg];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_user_reg <= res_status;
            m_data_reg <= res_data;
        end
    end

    assign sts.out_free = !m_valid_reg || m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tuser      = m_user_reg;
    assign m_tdata      = m_data_reg;

endmodule

`default_nettype wire

/* rtl/can_rx_acceptance_filter_fifo.sv */
// top level of the can receive path: acceptance filter in front of a frame ring
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tuser kind, s_tdata frame
//  m_        out        m_tvalid / m_tready  m_tuser status, m_tdata popped frame
//  cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// each transaction is accepted in the idle state, then filtered and applied
// to the ring in the execute state.
// execution waits while a previous result is still held in the output register.
// aresetn clears the filter registers, the ring pointers and the controller;
// the ring memory needs no clearing pass.
`default_nettype none

module can_rx_acceptance_filter_fifo #(
    parameter int RING_DEPTH   = canrxf_pkg::DEF_RING_DEPTH,
    parameter int FILTER_SLOTS = canrxf_pkg::DEF_FILTER_SLOTS
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire  [canrxf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [canrxf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [canrxf_pkg::KIND_W-1:0]      s_tuser,   // kind
    input  wire  [canrxf_pkg::TDATA_W-1:0]     s_tdata,   // frame_id, frame_dlc, frame_data
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [canrxf_pkg::STATUS_W-1:0]    m_tuser,   // status
    output logic [canrxf_pkg::TDATA_W-1:0]     m_tdata    // out_id, out_dlc, out_data
);
    import canrxf_pkg::*;

    canrxf_cmd_t cmd;
    canrxf_sts_t sts;

    canrxf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    canrxf_dp #(
        .RING_DEPTH   (RING_DEPTH),
        .FILTER_SLOTS (FILTER_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

/* rtl/canrxf_chk.sv */
// port-level checks on the can receive path, bound to the top level
`default_nettype none

module canrxf_chk (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [canrxf_pkg::STATUS_W-1:0]     m_tuser,
    input wire [canrxf_pkg::TDATA_W-1:0]      m_tdata
);
    import canrxf_pkg::*;

    // one transaction at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction was in progress");

    // a new result only appears from the execute cycle
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result presented without an executing transaction");

    // only a successful pop carries frame contents
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STATUS_DONE)) |-> (m_tdata == '0))
        else $error("non-zero payload on a result without a frame");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind can_rx_acceptance_filter_fifo canrxf_chk u_canrxf_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/can_rx_acceptance_filter_fifo_tb.sv */
// self-checking testbench for the can receive acceptance filter and frame ring
module can_rx_acceptance_filter_fifo_tb;
    import canrxf_pkg::*;

    localparam int RING_DEPTH      = DEF_RING_DEPTH;
    localparam int FILTER_SLOTS    = DEF_FILTER_SLOTS;
    localparam int HOLD_CYCLES     = 64;
    localparam int STALL_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int RANDOM_ROUNDS   = 8;
    localparam int ITEMS_PER_ROUND = 150;

    typedef struct {
        rx_status_t        status;
        logic [ID_W-1:0]   id;
        logic [DLC_W-1:0]  dlc;
        logic [DATA_W-1:0] data;
    } frame_result_t;

    class can_rx_scoreboard;
        logic [CNT_W-1:0]      filter_count;
        logic [CFG_DATA_W-1:0] filter_word [FILTER_SLOTS];
        logic [ID_W-1:0]       ring_id     [RING_DEPTH];
        logic [DLC_W-1:0]      ring_dlc    [RING_DEPTH];
        logic [DATA_W-1:0]     ring_data   [RING_DEPTH];
        int unsigned           wr_ptr;
        int unsigned           rd_ptr;
        frame_result_t         awaited_results [$];
        int                    mismatches;

        function new();
            filter_count = '0;
            foreach (filter_word[i]) filter_word[i] = '0;
            wr_ptr     = 0;
            rd_ptr     = 0;
            mismatches = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            if (index == REG_FILTER_COUNT) begin
                filter_count = value[CNT_W-1:0];
            end else if (index <= REG_FILTER_WORD_LAST &&
                         int'(index - REG_FILTER_WORD_0) < FILTER_SLOTS) begin
                filter_word[index - REG_FILTER_WORD_0] = value;
            end
        endfunction

        function bit id_accepted(logic [ID_W-1:0] id);
            int              active;
            int              i;
            logic [ID_W-1:0] mask;
            active = (filter_count > FILTER_SLOTS) ? FILTER_SLOTS : int'(filter_count);
            if (active == 0) return 1'b1;
            for (i = 0; i < active; i++) begin
                mask = filter_word[i][2*ID_W-1:ID_W];
                if ((id & mask) == (filter_word[i][ID_W-1:0] & mask)) return 1'b1;
            end
            return 1'b0;
        endfunction

        function rx_status_t store_frame(logic [ID_W-1:0] id, logic [DLC_W-1:0] dlc,
                                         logic [DATA_W-1:0] data);
            int unsigned next_ptr;
            next_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (next_ptr == rd_ptr) return STATUS_FULL;
            ring_id[wr_ptr]   = id;
            ring_dlc[wr_ptr]  = dlc;
            ring_data[wr_ptr] = data;
            wr_ptr = next_ptr;
            return STATUS_DONE;
        endfunction

        function void note_frame(kind_t kind, logic [TDATA_W-1:0] tdata);
            frame_result_t     res;
            logic [ID_W-1:0]   id;
            logic [DLC_W-1:0]  dlc;
            logic [DATA_W-1:0] data;
            id   = tdata[ID_W-1:0];
            dlc  = tdata[ID_W +: DLC_W];
            data = tdata[ID_W+DLC_W +: DATA_W];
            res.status = STATUS_DONE;
            res.id     = '0;
            res.dlc    = '0;
            res.data   = '0;
            case (kind)
                KIND_BUS: begin
                    res.status = id_accepted(id) ? store_frame(id, dlc, data) : STATUS_REJECT;
                end
                KIND_LOOP: begin
                    res.status = store_frame(id, dlc, data);
                end
                KIND_POP: begin
                    if (wr_ptr == rd_ptr) begin
                        res.status = STATUS_EMPTY;
                    end else begin
                        res.id   = ring_id[rd_ptr];
                        res.dlc  = ring_dlc[rd_ptr];
                        res.data = ring_data[rd_ptr];
                        rd_ptr   = (rd_ptr + 1) % RING_DEPTH;
                    end
                end
                default: ;
            endcase
            awaited_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] exp_value,
                                    logic [DATA_W-1:0] act_value);
            if (exp_value !== act_value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s expected %0h, got %0h", $time, name, exp_value, act_value);
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [TDATA_W-1:0] tdata);
            frame_result_t res;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result, status %0d", $time, status);
                return;
            end
            res = awaited_results.pop_front();
            compare_field("status", DATA_W'(res.status), DATA_W'(status));
            compare_field("out_id", DATA_W'(res.id), DATA_W'(tdata[ID_W-1:0]));
            compare_field("out_dlc", DATA_W'(res.dlc), DATA_W'(tdata[ID_W +: DLC_W]));
            compare_field("out_data", res.data, tdata[ID_W+DLC_W +: DATA_W]);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    kind_t                 s_tuser   = KIND_BUS;
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [STATUS_W-1:0]   m_tuser;
    logic [TDATA_W-1:0]    m_tdata;

    can_rx_scoreboard sb = new();

    bit tx_idle       = 1'b1;
    bit rx_idle       = 1'b1;
    bit hold_request  = 1'b0;
    int stall_cycles  = 0;

    can_rx_acceptance_filter_fifo i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // both sides are sampled at the edge, before any of this edge's updates land
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_frame(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("can_rx_acceptance_filter_fifo: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random hold-off per transaction while rx_idle is set, one long hold on request
    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 13) : 0;
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_frame(kind_t kind, logic [ID_W-1:0] id, logic [DLC_W-1:0] dlc,
                              logic [DATA_W-1:0] data);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(TDATA_W-FRAME_W){1'b0}}, data, dlc, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_register(index, value);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering and let every awaited result drain out of the block
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int                round;
        int                n;
        int                w;
        int                idx;
        int                pick;
        int                slot;
        int                count;
        bit                fill_phase;
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   mask;
        logic [ID_W-1:0]   match;
        logic [DLC_W-1:0]  dlc;
        logic [DATA_W-1:0] data;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers at reset: every bus frame passes
        send_frame(KIND_POP, '0, '0, '0);
        send_frame(KIND_BUS, 11'h000, 4'h0, 64'h0);
        send_frame(KIND_BUS, 11'h7ff, 4'hf, {DATA_W{1'b1}});
        send_frame(KIND_LOOP, 11'h555, 4'h8, 64'h0123_4567_89ab_cdef);
        send_frame(KIND_NONE, 11'h2aa, 4'h9, {$urandom, $urandom});
        repeat (4) send_frame(KIND_POP, '0, '0, '0);

        wait_idle();
        cfg_write(REG_FILTER_COUNT, 22'd2);
        cfg_write(REG_FILTER_WORD_0, {11'h7ff, 11'h123});
        cfg_write(CFG_IDX_W'(REG_FILTER_WORD_0 + 1), {11'h700, 11'h500});
        send_frame(KIND_BUS, 11'h123, 4'h1, 64'h1111_2222_3333_4444);
        send_frame(KIND_BUS, 11'h124, 4'h2, 64'h5555_6666_7777_8888);
        send_frame(KIND_BUS, 11'h5ab, 4'h3, 64'h9999_aaaa_bbbb_cccc);
        send_frame(KIND_LOOP, 11'h124, 4'h8, 64'hdddd_eeee_ffff_0000);
        send_frame(KIND_BUS, 11'h000, 4'h0, 64'h0);
        repeat (4) send_frame(KIND_POP, '0, '0, '0);

        // count above the slot number acts as all slots; writes past the map are dropped
        wait_idle();
        cfg_write(REG_FILTER_COUNT, 22'd7);
        cfg_write(CFG_IDX_W'(REG_FILTER_WORD_0 + 2), {11'h7ff, 11'h000});
        cfg_write(REG_FILTER_WORD_LAST, {CFG_DATA_W{1'b1}});
        for (idx = REG_FILTER_WORD_LAST + 1; idx < 2**CFG_IDX_W; idx++)
            cfg_write(CFG_IDX_W'(idx), {CFG_DATA_W{1'b1}});
        send_frame(KIND_BUS, 11'h7ff, 4'hc, {$urandom, $urandom});
        send_frame(KIND_BUS, 11'h000, 4'h4, {$urandom, $urandom});
        send_frame(KIND_BUS, 11'h3c3, 4'h5, {$urandom, $urandom});
        repeat (3) send_frame(KIND_POP, '0, '0, '0);

        for (round = 0; round < RANDOM_ROUNDS; round++) begin
            wait_idle();
            count = (round == 0) ? 0 : (round == 1) ? 7 : int'($urandom_range(0, 7));
            cfg_write(REG_FILTER_COUNT, CFG_DATA_W'(count));
            for (w = 0; w < FILTER_SLOTS; w++) begin
                mask  = ($urandom_range(0, 2) == 0) ? ID_W'($urandom)
                                                    : ID_W'($urandom & $urandom & $urandom);
                match = ID_W'($urandom);
                cfg_write(CFG_IDX_W'(REG_FILTER_WORD_0 + w), {mask, match});
            end
            if ($urandom_range(0, 1))
                cfg_write(CFG_IDX_W'(REG_FILTER_WORD_LAST + 1 + $urandom_range(0, 2)),
                          CFG_DATA_W'($urandom));
            tx_idle = (round % 4) != 3;
            rx_idle = (round % 4) != 3;
            if (round == 2) begin
                // keep offering while the result side holds off, so the input backs up
                tx_idle      = 1'b0;
                hold_request = 1'b1;
            end
            fill_phase = 1'b1;
            for (n = 0; n < ITEMS_PER_ROUND; n++) begin
                // mix bursts that fill the ring with bursts that drain it, each burst's direction picked at random
                if (n % 25 == 0) fill_phase = $urandom_range(0, 1);
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    kind = KIND_NONE;
                else if (pick < (fill_phase ? 80 : 25))
                    kind = ($urandom_range(0, 9) < 7) ? KIND_BUS : KIND_LOOP;
                else
                    kind = KIND_POP;
                slot = $urandom_range(0, FILTER_SLOTS - 1);
                id   = ID_W'($urandom);
                if ($urandom_range(0, 1)) begin
                    mask = sb.filter_word[slot][2*ID_W-1:ID_W];
                    id   = (sb.filter_word[slot][ID_W-1:0] & mask) | (id & ~mask);
                end
                dlc  = ($urandom_range(0, 9) == 0) ? DLC_W'($urandom_range(9, 15))
                                                   : DLC_W'($urandom_range(0, 8));
                data = {$urandom, $urandom};
                send_frame(kind, id, dlc, data);
            end
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
            $display("can_rx_acceptance_filter_fifo: match");
        end else begin
            $display("can_rx_acceptance_filter_fifo: mismatch");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/canrxf_pkg.sv
rtl/canrxf_ctrl.sv
rtl/canrxf_dp.sv
rtl/can_rx_acceptance_filter_fifo.sv
rtl/canrxf_chk.sv
tb/can_rx_acceptance_filter_fifo_tb.sv
